[sv/a2i_pkg.sv]
// a2i_pkg: shared widths, phase and status codes, character constants and
// the state and result structs of the string-to-integer converter.
// No dependencies.
`default_nettype none

package a2i_pkg;

  localparam int VALUE_BITS  = 64;
  localparam int OFFSET_BITS = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 88;
  localparam int VALUE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int OFFSET_W    = 16;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_SIGNED = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_BAD_BASE = 2'd2;

  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_BIN   = 6'd2;
  localparam logic [5:0] RADIX_OCT   = 6'd8;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] RADIX_HEX   = 6'd16;
  localparam logic [5:0] RADIX_AUTO  = 6'd0;
  localparam logic [5:0] RADIX_UNARY = 6'd1;
  localparam logic [5:0] DIGIT_NONE  = 6'd36;

  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [2:0]             phase;
    logic                   negative;
    logic [5:0]             base;
    logic [VALUE_BITS-1:0]  magnitude;
    logic                   overflowed;
    logic [OFFSET_BITS-1:0] position;
    logic [OFFSET_BITS-1:0] end_position;
  } a2i_state_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] end_offset;
  } a2i_res_t;

endpackage

`default_nettype wire

[sv/a2i_step.sv]
// a2i_step: next-state and result logic for one character of a conversion:
// start handling, whitespace, sign, prefix, digit multiply-add and saturation.
// Depends on a2i_pkg.
`default_nettype none

module a2i_step (
  input  a2i_pkg::a2i_state_t st,
  input  logic [7:0]          ch,
  input  logic                start_req,
  input  logic [5:0]          radix,
  output a2i_pkg::a2i_state_t st_nxt,
  output logic                emit,
  output a2i_pkg::a2i_res_t   res
);
  import a2i_pkg::*;

  localparam logic [VALUE_BITS-1:0]  HALF_V  = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0]  MAX_V   = ~HALF_V;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  a2i_state_t             s;
  logic                   bad_base;
  logic [7:0]             lc;
  logic                   is_space;
  logic                   is_sign;
  logic                   is_zero;
  logic [5:0]             eff_base;
  logic [5:0]             dig;
  logic                   dig_ok;
  logic                   prefix;
  logic [VALUE_BITS+5:0]  prod;
  logic [VALUE_BITS+5:0]  limit;
  logic [OFFSET_BITS-1:0] pos_adv;
  logic [VALUE_BITS-1:0]  val_v;
  logic [VALUE_BITS+VALUE_W-1:0] val_ext;
  logic [OFFSET_BITS+OFFSET_W-1:0] end_ext;

  always_comb begin
    s = st;
    if (start_req) begin
      s.negative     = 1'b0;
      s.magnitude    = '0;
      s.overflowed   = 1'b0;
      s.position     = '0;
      s.end_position = '0;
      s.base         = radix;
      s.phase        = PH_LEAD;
    end
    bad_base = start_req && (radix == RADIX_UNARY || radix > RADIX_MAX);
  end

  always_comb begin
    lc       = ch | CASE_BIT;
    is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
    is_zero  = (ch == CH_ZERO);

    if (s.phase == PH_ZERO && s.base == RADIX_AUTO) begin
      if (lc == CH_LX)      eff_base = RADIX_HEX;
      else if (lc == CH_LB) eff_base = RADIX_BIN;
      else                  eff_base = RADIX_OCT;
    end else if (s.base == RADIX_AUTO) begin
      eff_base = RADIX_DEC;
    end else begin
      eff_base = s.base;
    end
    if (eff_base < RADIX_BIN || eff_base > RADIX_MAX) eff_base = RADIX_DEC;

    if (ch >= CH_ZERO && ch <= CH_NINE)  dig = 6'(ch - CH_ZERO);
    else if (ch >= CH_UA && ch <= CH_UZ) dig = 6'(ch - CH_UA + 8'd10);
    else if (ch >= CH_LA && ch <= CH_LZ) dig = 6'(ch - CH_LA + 8'd10);
    else                                 dig = DIGIT_NONE;
    dig_ok = dig < eff_base;

    prefix = (s.phase == PH_ZERO) &&
             ((eff_base == RADIX_HEX && lc == CH_LX) ||
              (eff_base == RADIX_BIN && lc == CH_LB) ||
              (eff_base == RADIX_OCT && lc == CH_LO));

    prod  = {6'b0, s.magnitude} * {{VALUE_BITS{1'b0}}, eff_base}
          + {{VALUE_BITS{1'b0}}, dig};
    limit = {6'b0, (s.negative ? HALF_V : MAX_V)};

    pos_adv = (s.position == POS_MAX) ? s.position : s.position + 1'b1;
  end

  always_comb begin
    if (s.overflowed) val_v = s.negative ? HALF_V : MAX_V;
    else              val_v = s.negative ? (~s.magnitude + 1'b1) : s.magnitude;
    val_ext = {{VALUE_W{val_v[VALUE_BITS-1]}}, val_v};
    end_ext = {{OFFSET_W{1'b0}}, s.end_position};
  end

  always_comb begin
    st_nxt         = s;
    emit           = 1'b0;
    res.value      = val_ext[VALUE_W-1:0];
    res.status     = s.overflowed ? ST_OVERFLOW : ST_OK;
    res.end_offset = end_ext[OFFSET_W-1:0];
    if (bad_base) begin
      st_nxt.phase   = PH_IDLE;
      emit           = 1'b1;
      res.value      = '0;
      res.status     = ST_BAD_BASE;
      res.end_offset = '0;
    end else begin
      unique case (s.phase) inside
        PH_IDLE: begin
        end
        PH_LEAD, PH_SIGNED, PH_ZERO, PH_DIGITS: begin
          if (s.phase == PH_LEAD && is_space) begin
            st_nxt.position = pos_adv;
          end else if (s.phase == PH_LEAD && is_sign) begin
            st_nxt.negative = (ch == CH_MINUS);
            st_nxt.position = pos_adv;
            st_nxt.phase    = PH_SIGNED;
          end else if ((s.phase == PH_LEAD || s.phase == PH_SIGNED) && is_zero) begin
            st_nxt.position     = pos_adv;
            st_nxt.end_position = pos_adv;
            st_nxt.phase        = PH_ZERO;
          end else if (prefix) begin
            st_nxt.base     = eff_base;
            st_nxt.position = pos_adv;
            st_nxt.phase    = PH_DIGITS;
          end else begin
            st_nxt.base = eff_base;
            if (!dig_ok) begin
              emit         = 1'b1;
              st_nxt.phase = PH_IDLE;
            end else begin
              st_nxt.position     = pos_adv;
              st_nxt.end_position = pos_adv;
              st_nxt.phase        = PH_DIGITS;
              if (!s.overflowed) begin
                if (prod > limit) st_nxt.overflowed = 1'b1;
                else              st_nxt.magnitude  = prod[VALUE_BITS-1:0];
              end
            end
          end
        end
        default: begin
          st_nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ascii_to_signed_integer.sv]
// Character-serial string to signed 64-bit integer converter (strtol style).
// One character request is taken per clock, back to back, while the output is
// not stalled; the character that ends the number waits in the input register
// and its result is then captured in the output register. The cycle is set by
// the digit step: one multiply-add of the running magnitude by the base with
// a compare against the signed limit. A request with in_tuser high starts a
// conversion and samples the radix; a bad radix answers at once with status 2.
// Characters outside a conversion are dropped. Depends on a2i_pkg and a2i_step.
`default_nettype none

module ascii_to_signed_integer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [a2i_pkg::IN_TDATA_W-1:0]     in_tdata,  // ch[7:0], radix[13:8]
  input  logic                               in_tuser,  // start_req
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [a2i_pkg::OUT_TDATA_W-1:0]    out_tdata  // value[63:0], status[65:64],
                                                        // end_offset[81:66]
);
  import a2i_pkg::*;

  logic       in_vld_r;
  logic [7:0] ch_r;
  logic       start_r;
  logic [5:0] radix_r;
  logic       out_vld_r;
  a2i_res_t   res_r;
  a2i_state_t st_r;
  a2i_state_t st_nxt;
  logic       emit;
  a2i_res_t   res;
  logic       go;

  assign go        = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || go;

  a2i_step u_step (
    .st        (st_r),
    .ch        (ch_r),
    .start_req (start_r),
    .radix     (radix_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '0;
    end else begin
      if (in_tready) in_vld_r <= in_tvalid;
      if (go) st_r <= st_nxt;
      if (go && emit)      out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ch_r    <= in_tdata[7:0];
      radix_r <= in_tdata[13:8];
      start_r <= in_tuser;
    end
    if (go && emit) res_r <= res;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'b0, res_r.end_offset, res_r.status, res_r.value};

`ifndef SYNTH
  a_ovf_phase: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.overflowed |-> (st_r.phase == PH_DIGITS || st_r.phase == PH_IDLE))
    else $error("overflow flag outside digit phase");

  a_end_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.end_position <= st_r.position)
    else $error("end offset beyond position");

  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(go))
    else $error("result without a processed request");

  a_bad_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && res_r.status == ST_BAD_BASE) |->
      (res_r.value == '0 && res_r.end_offset == '0))
    else $error("bad base result not zero");
`endif

endmodule

`default_nettype wire
